// File: hw/rtl/dwis_pkg.sv
// Package for the DNA window insertion scanner: shared constants, base and
// state encodings, the symbol decoder and the window control struct.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dwis_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned WindowLengthDef = 30;
  localparam int unsigned PositionBitsDef = 32;

  // Fixed field widths.
  localparam int unsigned SymbolBits   = 8;
  localparam int unsigned ReadBits     = 60;
  localparam int unsigned MaxInsBits   = 5;
  localparam int unsigned LocationBits = 32;
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = ReadBits;

  // Configuration register indexes.
  localparam logic [CfgIndexBits-1:0] CfgReadPattern   = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgMaxInsertions = 2'd1;

  localparam logic [MaxInsBits-1:0] MaxInsReset = 5'd2;

  // Base codes and their ASCII characters.
  localparam logic [1:0] BaseA = 2'd0;
  localparam logic [1:0] BaseC = 2'd1;
  localparam logic [1:0] BaseG = 2'd2;
  localparam logic [1:0] BaseT = 2'd3;

  localparam logic [SymbolBits-1:0] CharA = 8'h41;
  localparam logic [SymbolBits-1:0] CharC = 8'h43;
  localparam logic [SymbolBits-1:0] CharG = 8'h47;
  localparam logic [SymbolBits-1:0] CharT = 8'h54;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } dwis_state_e;

  // Requests to the window register in one cycle: clear is applied first,
  // then the push of a base, then the position step.
  typedef struct packed {
    logic       clear;
    logic       push;
    logic [1:0] base;
    logic       advance;
  } dwis_win_ctrl_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } dwis_win_stat_t;

  // Returns {valid, base code}; valid is low for any byte but A, C, G and T.
  function automatic logic [2:0] decode_symbol(input logic [SymbolBits-1:0] sym);
    logic [2:0] res;
    case (sym)
      CharA:   res = {1'b1, BaseA};
      CharC:   res = {1'b1, BaseC};
      CharG:   res = {1'b1, BaseG};
      CharT:   res = {1'b1, BaseT};
      default: res = 3'b000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dwis_window.sv
// Window register of the scanner: the last bases, their count and the
// saturating base position. Depends on dwis_pkg.
`default_nettype none

module dwis_window
  import dwis_pkg::*;
#(
  parameter int unsigned WindowLength = WindowLengthDef,
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dwis_win_ctrl_t            ctrl_i,
  output dwis_win_stat_t                 stat_o,
  output logic [2*WindowLength-1:0]      window_o,
  output logic [PositionBits-1:0]        position_o
);

  localparam int unsigned HeldBits = $clog2(WindowLength + 1);

  logic [2*WindowLength-1:0] window_q, window_d, window_base;
  logic [HeldBits-1:0]       held_q, held_d, held_base;
  logic [PositionBits-1:0]   pos_q, pos_d, pos_base;

  always_comb begin
    window_base = ctrl_i.clear ? '0 : window_q;
    held_base   = ctrl_i.clear ? '0 : held_q;
    pos_base    = ctrl_i.clear ? '0 : pos_q;

    window_d = window_base;
    held_d   = held_base;
    pos_d    = pos_base;

    if (ctrl_i.push) begin
      if (held_base < HeldBits'(WindowLength)) begin
        // Filling: the new base lands at the first free slot.
        for (int j = 0; j < WindowLength; j++) begin
          if (held_base == HeldBits'(j)) begin
            window_d[2*j +: 2] = ctrl_i.base;
          end
        end
        held_d = held_base + HeldBits'(1);
      end else begin
        // Full: the oldest base drops out and the new one becomes the newest.
        window_d = {ctrl_i.base, window_base[2*WindowLength-1:2]};
      end
    end

    if (ctrl_i.advance && (pos_base != '1)) begin
      pos_d = pos_base + PositionBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      held_q   <= '0;
      pos_q    <= '0;
    end else begin
      window_q <= window_d;
      held_q   <= held_d;
      pos_q    <= pos_d;
    end
  end

  assign stat_o.full        = (held_q == HeldBits'(WindowLength));
  assign stat_o.almost_full = (held_q == HeldBits'(WindowLength - 1));
  assign window_o           = window_q;
  assign position_o         = pos_q;

endmodule

`default_nettype wire

// File: hw/rtl/dwis_ins_unit.sv
// Iterative insertion counter: one read position per cycle with a shared
// compare and a running insertion count. Depends on dwis_pkg.
`default_nettype none

module dwis_ins_unit
  import dwis_pkg::*;
#(
  parameter int unsigned WindowLength = WindowLengthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [2*WindowLength-1:0]    window_i,
  input  wire logic [ReadBits-1:0]          read_pattern_i,
  input  wire logic [MaxInsBits-1:0]        max_ins_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic                              match_o
);

  localparam int unsigned IdxBits  = $clog2(WindowLength);
  localparam int unsigned CntBits  = $clog2(WindowLength + 1);
  localparam int unsigned CmpBits  = (CntBits > MaxInsBits) ? CntBits : MaxInsBits;
  localparam int unsigned CopyBits = (2 * WindowLength < ReadBits) ? 2 * WindowLength
                                                                   : ReadBits;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               match_q, match_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic [CntBits-1:0] ins_q, ins_d;

  logic [2*WindowLength-1:0] read_ext;
  logic [1:0]         read_arr [WindowLength];
  logic [1:0]         win_arr  [WindowLength];
  logic [IdxBits-1:0] win_idx;
  logic               mismatch;
  logic [CntBits-1:0] ins_next;

  // Read bases beyond the register are taken as A.
  always_comb begin
    read_ext = '0;
    for (int k = 0; k < CopyBits; k++) begin
      read_ext[k] = read_pattern_i[k];
    end
    for (int j = 0; j < WindowLength; j++) begin
      read_arr[j] = read_ext[2*j +: 2];
      win_arr[j]  = window_i[2*j +: 2];
    end
  end

  // The count never exceeds the read index, so it fits the index width here.
  assign win_idx  = idx_q - ins_q[IdxBits-1:0];
  assign mismatch = (read_arr[idx_q] != win_arr[win_idx]);
  assign ins_next = ins_q + CntBits'(mismatch);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    match_d = match_q;
    idx_d   = idx_q;
    ins_d   = ins_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      ins_d  = '0;
    end else if (busy_q) begin
      ins_d = ins_next;
      if (idx_q == IdxBits'(WindowLength - 1)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        match_d = (CmpBits'(ins_next) <= CmpBits'(max_ins_i));
      end else begin
        idx_d = idx_q + IdxBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      ins_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
      ins_q  <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign match_o = match_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (CmpBits'(ins_q) <= CmpBits'(idx_q)))
    else $error("insertion count passed the read index");

  a_done_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while the walk is still running");

  a_walk_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (idx_q == '0) && (ins_q == '0))
    else $error("walk started with stale index or count");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/dna_window_insertion_scanner.sv
// Top level of the DNA window insertion scanner: stream ports, configuration
// registers, sequencer and output register. Depends on dwis_pkg, dwis_window
// and dwis_ins_unit.
//
// The scanner takes one genome character per input transfer and skips every
// byte other than ASCII A, C, G and T. It keeps the last WindowLength bases;
// once the window is full, every new base starts a greedy insertion-tolerant
// comparison against the configured read, walked by one shared compare unit at
// one read position per cycle. An item that does not fill or refresh a full
// window needs no comparison; one that ends the scan with a not-found result
// also passes through the emit state. An item that leads to a comparison holds
// the input through the accepting cycle, the walk over every read position and
// the judging of the count. A comparison that gives a result then moves it into
// the output register from the emit state, which lasts for as long as an
// earlier result still waits there. The
// first window with at most max_insertions insertions gives a found result
// (tuser 1) with the window start in tdata; after that the block drops input
// until a transfer with first_of_scan set (slave tuser). A scan whose last
// character (tlast) passes without a match gives a not-found result with
// location zero. The result sits in an output register, so the next character
// is accepted while a result waits to be taken. The base position saturates
// at its largest value. Configuration writes are always accepted and must only
// be made while the block is idle.
`default_nettype none

module dna_window_insertion_scanner
  import dwis_pkg::*;
#(
  parameter int unsigned WindowLength = WindowLengthDef,
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Input stream.
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire logic [SymbolBits-1:0]    s_axis_tdata_i,   // [7:0] symbol
  input  wire logic [0:0]               s_axis_tuser_i,   // [0] first_of_scan
  input  wire logic                     s_axis_tlast_i,   // last_of_scan
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output logic [LocationBits-1:0]       m_axis_tdata_o,   // [31:0] location
  output logic [0:0]                    m_axis_tuser_o,   // [0] found
  // Configuration writes.
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0]   cfg_data_i
);

  localparam int unsigned LocWide = (PositionBits > LocationBits) ? PositionBits
                                                                  : LocationBits;

  // Configuration registers.
  logic [ReadBits-1:0]   read_pattern_q;
  logic [MaxInsBits-1:0] max_ins_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pattern_q <= '0;
      max_ins_q      <= MaxInsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgReadPattern:   read_pattern_q <= cfg_data_i[ReadBits-1:0];
        CfgMaxInsertions: max_ins_q      <= cfg_data_i[MaxInsBits-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and result bookkeeping.
  dwis_state_e state_q, state_d;
  logic        finished_q, finished_d;
  logic        last_q, last_d;
  logic        pend_found_q, pend_found_d;
  logic [LocationBits-1:0] pend_loc_q, pend_loc_d;
  logic        m_valid_q, m_valid_d;
  logic        out_found_q;
  logic [LocationBits-1:0] out_loc_q;
  logic        load_out;

  dwis_win_ctrl_t           win_ctrl;
  dwis_win_stat_t           win_stat;
  logic [2*WindowLength-1:0] window;
  logic [PositionBits-1:0]  position;
  logic                     ins_start, ins_busy, ins_done, ins_match;

  dwis_window #(
    .WindowLength (WindowLength),
    .PositionBits (PositionBits)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (win_ctrl),
    .stat_o     (win_stat),
    .window_o   (window),
    .position_o (position)
  );

  dwis_ins_unit #(
    .WindowLength (WindowLength)
  ) u_ins_unit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (ins_start),
    .window_i       (window),
    .read_pattern_i (read_pattern_q),
    .max_ins_i      (max_ins_q),
    .busy_o         (ins_busy),
    .done_o         (ins_done),
    .match_o        (ins_match)
  );

  // Decoding of the accepted character.
  logic       in_accept, first_scan, finished_eff, live, sym_ok, push, go_scan;
  logic       early_nf, scan_done, hit, miss, miss_nf, out_free;
  logic [2:0] dec;
  logic [LocWide-1:0] loc_full;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign first_scan   = s_axis_tuser_i[0];
  assign finished_eff = finished_q && !first_scan;
  assign live         = in_accept && !finished_eff;
  assign dec          = decode_symbol(s_axis_tdata_i);
  assign sym_ok       = dec[2];
  assign push         = live && sym_ok;
  // A window that holds at least all but one base is full after this push.
  assign go_scan      = push && !first_scan && (win_stat.full || win_stat.almost_full);
  // The last character passed without any comparison to wait for.
  assign early_nf     = live && s_axis_tlast_i && !go_scan;
  assign scan_done    = (state_q == StScan) && ins_done;
  assign hit          = scan_done && ins_match;
  assign miss         = scan_done && !ins_match;
  assign miss_nf      = miss && last_q;
  assign out_free     = !m_valid_q || m_axis_tready_i;

  // The position still names the newest base while the comparison runs.
  assign loc_full = LocWide'(position) - LocWide'(WindowLength - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (go_scan) begin
          state_d = StScan;
        end else if (early_nf) begin
          state_d = StEmit;
        end
      end
      StScan: begin
        if (hit || miss_nf) begin
          state_d = StEmit;
        end else if (miss) begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    win_ctrl.clear   = in_accept && first_scan;
    win_ctrl.push    = push;
    win_ctrl.base    = dec[1:0];
    win_ctrl.advance = (push && !go_scan) || miss;
    ins_start        = go_scan;

    finished_d   = finished_q;
    last_d       = last_q;
    pend_found_d = pend_found_q;
    pend_loc_d   = pend_loc_q;

    if (in_accept && first_scan) begin
      finished_d = 1'b0;
    end
    if (go_scan) begin
      last_d = s_axis_tlast_i;
    end
    if (early_nf || miss_nf) begin
      finished_d   = 1'b1;
      pend_found_d = 1'b0;
      pend_loc_d   = '0;
    end
    if (hit) begin
      finished_d   = 1'b1;
      pend_found_d = 1'b1;
      pend_loc_d   = loc_full[LocationBits-1:0];
    end

    load_out  = (state_q == StEmit) && out_free;
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      finished_q <= 1'b0;
      last_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      finished_q <= finished_d;
      last_q     <= last_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_found_q <= pend_found_d;
    pend_loc_q   <= pend_loc_d;
    if (load_out) begin
      out_found_q <= pend_found_q;
      out_loc_q   <= pend_loc_q;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = out_loc_q;
  assign m_axis_tuser_o[0] = out_found_q;

`ifndef SYNTHESIS
  a_idle_means_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !ins_busy)
    else $error("input accepted while the compare unit is busy");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == StEmit))
    else $error("result register loaded outside the emit state");

  a_emit_marks_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> finished_q)
    else $error("result pending without the scan marked finished");

  a_scan_ends_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && !ins_busy && !ins_done) |-> $past(ins_start))
    else $error("scan state without a running comparison");
`endif

endmodule

`default_nettype wire

// File: sim/dwis_checker.sv
// Scoreboard for the DNA window insertion scanner: watches the input, result
// and configuration channels, predicts every result and compares it.
// Depends on dwis_pkg for field widths, register indexes and character codes.
`default_nettype none

module dwis_checker
  import dwis_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  input  wire logic                     s_axis_tready_i,
  input  wire logic [SymbolBits-1:0]    s_axis_tdata_i,   // [7:0] symbol
  input  wire logic [0:0]               s_axis_tuser_i,   // [0] first_of_scan
  input  wire logic                     s_axis_tlast_i,   // last_of_scan
  input  wire logic                     m_axis_tvalid_i,
  input  wire logic                     m_axis_tready_i,
  input  wire logic [LocationBits-1:0]  m_axis_tdata_i,   // [31:0] location
  input  wire logic [0:0]               m_axis_tuser_i,   // [0] found
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [CfgIndexBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0]   cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   live_items_o
);

  localparam int unsigned WinLen  = WindowLengthDef;
  localparam int unsigned PosBits = PositionBitsDef;

  typedef struct packed {
    logic                    found;
    logic [LocationBits-1:0] location;
  } scan_result_t;

  // Shadow copy of the configuration and of the scan state.
  logic [ReadBits-1:0]   read_bases;
  logic [MaxInsBits-1:0] ins_limit;
  logic [2*WinLen-1:0]   window;
  int unsigned           held;
  logic [PosBits-1:0]    position;
  bit                    scan_done;
  int unsigned           fails;
  int unsigned           live_items;

  scan_result_t expected_results[$];

  // Base code of a genome character, or -1 for a byte that is skipped.
  function automatic int base_code_of(input logic [SymbolBits-1:0] sym);
    if (sym == CharA) return int'(BaseA);
    if (sym == CharC) return int'(BaseC);
    if (sym == CharG) return int'(BaseG);
    if (sym == CharT) return int'(BaseT);
    return -1;
  endfunction

  // Greedy walk: a read base that differs from the window base it is lined up
  // with counts as an insertion and shifts the rest of the read by one.
  function automatic int unsigned greedy_insertions();
    int unsigned ins;
    int unsigned pos_in_window;
    int unsigned i;
    ins = 0;
    for (i = 0; i < WinLen; i++) begin
      pos_in_window = i - ins;
      if (read_bases[2*i +: 2] != window[2*pos_in_window +: 2]) ins++;
    end
    return ins;
  endfunction

  task automatic take_symbol(input logic [SymbolBits-1:0] sym, input logic is_first,
                             input logic is_last);
    int code;
    scan_result_t res;
    if (is_first) begin
      window    = '0;
      held      = 0;
      position  = '0;
      scan_done = 1'b0;
    end
    if (scan_done) return;
    live_items++;
    code = base_code_of(sym);
    if (code >= 0) begin
      if (held < WinLen) begin
        window[2*held +: 2] = code[1:0];
        held++;
      end else begin
        window = {code[1:0], window[2*WinLen-1:2]};
      end
      if (held == WinLen && greedy_insertions() <= ins_limit) begin
        res.found    = 1'b1;
        res.location = LocationBits'(position - PosBits'(WinLen - 1));
        expected_results.push_back(res);
        scan_done = 1'b1;
        return;
      end
      if (position != '1) position++;
    end
    if (is_last) begin
      res.found    = 1'b0;
      res.location = '0;
      expected_results.push_back(res);
      scan_done = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scan_result_t want;
    if (!rst_ni) begin
      read_bases = '0;
      ins_limit  = MaxInsReset;
      window     = '0;
      held       = 0;
      position   = '0;
      scan_done  = 1'b0;
      fails      = 0;
      live_items = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      live_items_o <= 0;
    end else begin
      // A result leaving now belongs to an item accepted earlier, so it is
      // matched before this edge's input transfer is predicted.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: found=%0d location=%0d",
                 m_axis_tuser_i[0], m_axis_tdata_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser_i[0] !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found,
                   m_axis_tuser_i[0]);
            fails++;
          end
          if (m_axis_tdata_i !== want.location) begin
            $error("location mismatch: expected %0d, actual %0d", want.location,
                   m_axis_tdata_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgReadPattern:   read_bases = cfg_data_i[ReadBits-1:0];
          CfgMaxInsertions: ins_limit  = cfg_data_i[MaxInsBits-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_symbol(s_axis_tdata_i, s_axis_tuser_i[0], s_axis_tlast_i);
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
      live_items_o <= live_items;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_dna_window_insertion_scanner.sv
// Testbench top for the DNA window insertion scanner: clock, reset, genome
// stimulus with random gaps, result back-pressure and the final verdict.
// Depends on dwis_pkg, the scanner RTL and dwis_checker.
`default_nettype none

module tb_dna_window_insertion_scanner;
  import dwis_pkg::*;

  // Roughly this many characters reach the scanner while a scan is open.
  localparam int unsigned ItemTarget = 1100;
  // Long enough for a comparison that holds the input to run out before the
  // block is assumed to be idle.
  localparam int unsigned SettleCycles = WindowLengthDef + 10;
  // The slowest correct run stays far below this many cycles.
  localparam int unsigned CycleLimit = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All inputs of the block start at known values.
  logic                    s_valid = 1'b0;
  logic [SymbolBits-1:0]   s_data  = '0;
  logic [0:0]              s_user  = '0;
  logic                    s_last  = 1'b0;
  logic                    s_ready;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [LocationBits-1:0] m_data;
  logic [0:0]              m_user;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned live_items;
  int unsigned cycle_count = 0;

  // Stimulus state: the read currently programmed and whether the sender is
  // in a stretch without gaps.
  logic [ReadBits-1:0] cur_read = '0;
  bit                  tx_calm  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dna_window_insertion_scanner DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  dwis_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .live_items_o    (live_items)
  );

  // Any run that gets this far has hung somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Gap lengths: mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [SymbolBits-1:0] base_char(input logic [1:0] code);
    case (code)
      BaseA:   return CharA;
      BaseC:   return CharC;
      BaseG:   return CharG;
      default: return CharT;
    endcase
  endfunction

  // The result side stalls at random, with calm stretches in between so that
  // results also leave back to back.
  initial begin : result_sink
    int unsigned stall;
    bit rx_calm;
    stall   = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        m_ready <= 1'b0;
        stall--;
      end else begin
        m_ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // One character transfer. The valid is left high afterwards so that back to
  // back transfers never lower and raise it in the same step.
  task automatic send_symbol(input logic [SymbolBits-1:0] sym, input bit is_first,
                             input bit is_last);
    int unsigned gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid   <= 1'b1;
    s_data    <= sym;
    s_user[0] <= is_first;
    s_last    <= is_last;
    do @(posedge clk); while (!s_ready);
  endtask

  // Holds the input back until every expected result has left, then lets a
  // comparison that gives no result run out before anything is reprogrammed.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes both registers in back-to-back transfers; called only when idle.
  task automatic program_scanner(input logic [ReadBits-1:0] read_value,
                                 input logic [MaxInsBits-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CfgReadPattern;
    cfg_data  <= CfgDataBits'(read_value);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CfgMaxInsertions;
    cfg_data  <= CfgDataBits'(limit);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_read  = read_value;
  endtask

  // A scan that carries the programmed read with a few bases dropped, so the
  // greedy walk has insertions to count, wrapped in random bases and with a
  // sprinkling of bytes that are not bases at all.
  task automatic run_read_scan();
    logic [SymbolBits-1:0] genome[$];
    bit                    dropped[WindowLengthDef];
    int unsigned           n;
    int unsigned           i;
    bit                    close_scan;
    for (i = 0; i < WindowLengthDef; i++) dropped[i] = 1'b0;
    n = $urandom_range(0, 4);
    repeat (n) dropped[$urandom_range(0, WindowLengthDef - 1)] = 1'b1;
    n = $urandom_range(0, 10);
    repeat (n) genome.push_back(base_char(2'($urandom)));
    for (i = 0; i < WindowLengthDef; i++) begin
      if ($urandom_range(0, 19) == 0) genome.push_back(8'($urandom));
      if (!dropped[i]) genome.push_back(base_char(cur_read[2*i +: 2]));
    end
    n = $urandom_range(0, 10);
    repeat (n) genome.push_back(base_char(2'($urandom)));
    // Sometimes the final byte is one that gets skipped.
    if ($urandom_range(0, 9) == 0) genome.push_back(8'($urandom));
    // Now and then the scan is abandoned and the next one simply restarts.
    close_scan = ($urandom_range(0, 7) != 0);
    for (i = 0; i < genome.size(); i++)
      send_symbol(genome[i], i == 0, close_scan && i == genome.size() - 1);
  endtask

  // Short runs of raw bytes and bases with the scan marks set at random.
  task automatic run_noise_scan();
    int unsigned n;
    int unsigned i;
    logic [SymbolBits-1:0] sym;
    bit is_first;
    n = $urandom_range(1, 12);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) sym = 8'($urandom);
      else sym = base_char(2'($urandom));
      if (i == 0) is_first = ($urandom_range(0, 3) != 0);
      else is_first = ($urandom_range(0, 9) == 0);
      send_symbol(sym, is_first, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin : stimulus
    logic [ReadBits-1:0]   read_value;
    logic [MaxInsBits-1:0] limit;
    int unsigned           pick;
    int unsigned           i;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: a lone skipped byte that ends the scan still gives
    // not-found, as does a scan of one skipped byte and one base.
    send_symbol(8'h00, 1'b1, 1'b1);
    send_symbol(8'hFF, 1'b1, 1'b0);
    send_symbol(CharA, 1'b0, 1'b1);
    settle();

    // An all-T read with no insertions allowed matches exactly on the final
    // byte, so only the found result comes. Afterwards even an end mark is
    // dropped until a new scan starts.
    program_scanner('1, '0);
    for (i = 0; i < WindowLengthDef; i++)
      send_symbol(CharT, i == 0, i == WindowLengthDef - 1);
    send_symbol(CharG, 1'b0, 1'b1);
    send_symbol(CharC, 1'b0, 1'b0);

    // Random phases, each with its own read and insertion limit, including
    // the all-A and all-T reads and limits that accept every full window.
    while (live_items < ItemTarget) begin
      settle();
      pick = $urandom_range(0, 7);
      if (pick == 0) read_value = '0;
      else if (pick == 1) read_value = '1;
      else read_value = ReadBits'({$urandom, $urandom});
      pick = $urandom_range(0, 15);
      if (pick < 2) limit = '0;
      else if (pick < 4) limit = 5'd30;
      else if (pick == 4) limit = '1;
      else if (pick == 5) limit = 5'd29;
      else limit = 5'($urandom_range(1, 5));
      program_scanner(read_value, limit);
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat (6) begin
        if ($urandom_range(0, 9) < 6) run_read_scan();
        else run_noise_scan();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: dna_window_insertion_scanner.f
hw/rtl/dwis_pkg.sv
hw/rtl/dwis_window.sv
hw/rtl/dwis_ins_unit.sv
hw/rtl/dna_window_insertion_scanner.sv
sim/dwis_checker.sv
sim/tb_dna_window_insertion_scanner.sv
